// ----- design/csem_pkg.sv -----
// Package for the counting semaphore with timed waits.
// Holds request/result structs, mode and result-kind codes, controller states.
// No dependencies.
package csem_pkg;

  localparam int unsigned ValueMax = 65535;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_SIGNAL = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_GRANTED  = 3'd0,
    KIND_BLOCKED  = 3'd1,
    KIND_RELEASED = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         thread_id;
    logic [15:0]        max_wait;
    logic signed [15:0] signal_count;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         thread_id_res;
    logic               by_signal;
    logic signed [15:0] return_value;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;   // capture request
    logic step;       // process one queue entry, advance walk
    logic finish;     // emit single/done result
    logic emit;       // result register loaded this cycle
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic walk_needed; // request needs a queue walk
    logic walk_end;    // current entry is the last one
    logic rel_hit;     // current entry is released
  } sts_t;

endpackage

// ----- design/csem_datapath.sv -----
// Datapath: semaphore value, waiter queue memories, walk index, result build.
// Depends on csem_pkg.
module csem_datapath #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i,
  input  csem_pkg::req_t  req_i,
  input  csem_pkg::cmd_t  cmd_i,
  output csem_pkg::sts_t  sts_o,
  output csem_pkg::res_t  res_o
);
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [7:0]  thr_mem  [QueueDepth];
  logic [15:0] time_mem [QueueDepth];
  logic        timed_mem[QueueDepth];

  csem_pkg::req_t     req_q;
  logic signed [16:0] val_q, val_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    rd_q;     // read index during walk
  logic [CntW-1:0]    wr_q;     // compaction write index
  logic [CntW-1:0]    rel_q;    // released so far
  logic [16:0]        amount;
  logic               sig_neg;
  csem_pkg::res_t     res_q;

  always_comb begin
    sig_neg = req_q.signal_count[15];
    amount  = (req_q.signal_count == '0) ? 17'd1 : {1'b0, req_q.signal_count};
  end

  // Current entry, registered ahead of use: entry 0 on capture, the next on each step.
  logic [CntW-1:0] rd_nxt;
  logic [IdxW-1:0] nxt_idx, wr_idx;
  logic [7:0]  cur_thr_q;
  logic [15:0] cur_time_q;
  logic        cur_timed_q, expire, release_it;
  assign rd_nxt    = cmd_i.load_req ? '0 : (rd_q + CntW'(1));
  assign nxt_idx   = rd_nxt[IdxW-1:0];
  assign wr_idx    = wr_q[IdxW-1:0];
  assign expire    = cur_timed_q && (cur_time_q <= 16'd1);
  // Signal releases the first min(amount, count); tick releases expired ones.
  assign release_it = (req_q.mode == csem_pkg::MODE_SIGNAL)
                      ? ({{(17-CntW){1'b0}}, rel_q} < amount) : expire;

  logic walk_possible;
  always_comb begin
    walk_possible = 1'b0;
    if (req_i.mode == csem_pkg::MODE_TICK) walk_possible = 1'b1;
    if (req_i.mode == csem_pkg::MODE_SIGNAL && !req_i.signal_count[15]) walk_possible = 1'b1;
  end
  assign sts_o.walk_needed = walk_possible && (cnt_q != '0);
  assign sts_o.walk_end    = (rd_q + CntW'(1)) >= cnt_q;
  assign sts_o.rel_hit     = release_it;

  function automatic logic signed [16:0] sat_add(logic signed [16:0] v, logic [16:0] a);
    logic signed [18:0] s;
    s = 19'(v) + $signed({2'b00, a});
    if (s > $signed(19'(csem_pkg::ValueMax))) s = $signed(19'(csem_pkg::ValueMax));
    return s[16:0];
  endfunction

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    if (cmd_i.finish) begin
      case (req_q.mode)
        csem_pkg::MODE_WAIT: begin
          if (val_q > 17'sd0) val_d = val_q - 17'sd1;
          else if (cnt_q < CntW'(QueueDepth)) begin
            val_d = val_q - 17'sd1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        csem_pkg::MODE_SIGNAL: if (!sig_neg) begin
          val_d = sat_add(val_q, amount);
          cnt_d = wr_q;
        end
        csem_pkg::MODE_TICK: begin
          val_d = sat_add(val_q, {{(17-CntW){1'b0}}, rel_q});
          cnt_d = wr_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      cnt_q <= '0;
      rd_q  <= '0;
      wr_q  <= '0;
      rel_q <= '0;
    end else if (cfg_we_i) begin
      val_q <= {1'b0, cfg_data_i};
      cnt_q <= '0;
    end else begin
      val_q <= val_d;
      cnt_q <= cnt_d;
      if (cmd_i.load_req) begin
        rd_q  <= '0;
        wr_q  <= '0;
        rel_q <= '0;
      end else if (cmd_i.step) begin
        rd_q <= rd_q + CntW'(1);
        if (release_it) rel_q <= rel_q + CntW'(1);
        else            wr_q  <= wr_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    // Fetch the entry the walk looks at next; writes only land at or behind rd_q.
    if (cmd_i.load_req || cmd_i.step) begin
      cur_thr_q   <= thr_mem[nxt_idx];
      cur_time_q  <= time_mem[nxt_idx];
      cur_timed_q <= timed_mem[nxt_idx];
    end
    // Compact kept entries toward the head; write never passes read.
    if (cmd_i.step && !release_it) begin
      thr_mem[wr_idx]   <= cur_thr_q;
      timed_mem[wr_idx] <= cur_timed_q;
      time_mem[wr_idx]  <= (req_q.mode == csem_pkg::MODE_TICK && cur_timed_q)
                           ? cur_time_q - 16'd1 : cur_time_q;
    end
    if (cmd_i.finish && req_q.mode == csem_pkg::MODE_WAIT && val_q <= 17'sd0
        && cnt_q < CntW'(QueueDepth)) begin
      thr_mem[cnt_q[IdxW-1:0]]   <= req_q.thread_id;
      time_mem[cnt_q[IdxW-1:0]]  <= req_q.max_wait;
      timed_mem[cnt_q[IdxW-1:0]] <= (req_q.max_wait != '0);
    end
    if (cmd_i.step && release_it) begin
      res_q.kind          <= csem_pkg::KIND_RELEASED;
      res_q.thread_id_res <= cur_thr_q;
      res_q.by_signal     <= (req_q.mode == csem_pkg::MODE_SIGNAL);
      res_q.return_value  <= (req_q.mode == csem_pkg::MODE_SIGNAL) ? 16'sd1 : 16'sd0;
      res_q.last          <= 1'b0;
    end else if (cmd_i.finish) begin
      res_q.thread_id_res <= '0;
      res_q.by_signal     <= 1'b0;
      res_q.return_value  <= '0;
      res_q.last          <= 1'b1;
      res_q.kind          <= csem_pkg::KIND_DONE;
      case (req_q.mode)
        csem_pkg::MODE_WAIT: begin
          res_q.thread_id_res <= req_q.thread_id;
          if (val_q > 17'sd0) begin
            res_q.kind         <= csem_pkg::KIND_GRANTED;
            res_q.by_signal    <= 1'b1;
            res_q.return_value <= 16'sd1;
          end else if (cnt_q < CntW'(QueueDepth)) res_q.kind <= csem_pkg::KIND_BLOCKED;
          else res_q.kind <= csem_pkg::KIND_FULL;
        end
        csem_pkg::MODE_SIGNAL: begin
          if (sig_neg) res_q.return_value <= req_q.signal_count;
          else if (req_q.signal_count != '0) res_q.return_value <= 16'(rel_q);
        end
        csem_pkg::MODE_TICK: res_q.return_value <= 16'(rel_q);
        default: ;
      endcase
    end
  end

  assign res_o = res_q;

  // Emission only happens from step-with-release or finish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !cmd_i.finish) else $error("step and finish together");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= rd_q) else $error("compaction write passed read");
endmodule

// ----- design/csem_ctrl.sv -----
// Controller FSM: sequences request capture, queue walk and result hand-off.
// Depends on csem_pkg.
module csem_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           res_last_i,
  input  csem_pkg::sts_t sts_i,
  output csem_pkg::cmd_t cmd_o
);
  csem_pkg::state_e state_q, state_d;
  logic ov_q, ov_d;
  logic out_free;

  // Output register may be reloaded when empty or being taken.
  assign out_free = !ov_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      csem_pkg::ST_IDLE:
        if (in_valid_i) state_d = sts_i.walk_needed ? csem_pkg::ST_WALK : csem_pkg::ST_DONE;
      csem_pkg::ST_WALK:
        if (out_free && sts_i.walk_end) state_d = csem_pkg::ST_DONE;
      csem_pkg::ST_DONE:
        if (out_free) state_d = csem_pkg::ST_IDLE;
      default: state_d = csem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      csem_pkg::ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      csem_pkg::ST_WALK: begin
        cmd_o.step = out_free;
        cmd_o.emit = out_free && sts_i.rel_hit;
      end
      csem_pkg::ST_DONE: begin
        cmd_o.finish = out_free;
        cmd_o.emit   = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_o.emit) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csem_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != csem_pkg::ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (out_valid_o && res_last_i)) else $error("done result missing last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |-> !cmd_o.emit) else $error("result overwritten");
endmodule

// ----- design/counting_semaphore_timed_wait.sv -----
// Top level of the counting semaphore with timed waits.
// Joins csem_ctrl and csem_datapath; depends on csem_pkg.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  csem_pkg::req_t
//   out       output     out_valid/out_stall csem_pkg::res_t
//   cfg       input      cfg_valid/cfg_ready initial_value, 16 bit
//
// A wait, unused mode, negative signal, or signal/tick on an empty queue goes
// straight to the done state and gives its single result; the next request is
// taken once the controller is back in idle. Otherwise the request walks every
// queued waiter, one entry per cycle while the output is not stalled, each
// release registered as a result at its step, then the done result. Reset
// empties the queue and clears the value; a stalled output holds the walk in
// place. One request at a time.
module counting_semaphore_timed_wait #(
  parameter int unsigned QueueDepth = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  csem_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csem_pkg::res_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  csem_pkg::cmd_t cmd;
  csem_pkg::sts_t sts;

  // The user must write configuration only while idle; the block does not enforce it and always takes it.
  assign cfg_ready_o = 1'b1;

  csem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_last_i  (out_data_o.last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  csem_datapath #(.QueueDepth(QueueDepth)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (out_data_o)
  );
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for counting_semaphore_timed_wait.
// Drives wait, signal and tick requests, predicts every result, checks in order.
// Depends on csem_pkg and the counting_semaphore_timed_wait RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 16;
  localparam int ValCap = 65535;
  localparam int ValFloor = -65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  csem_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  csem_pkg::res_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  counting_semaphore_timed_wait u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow semaphore state
  int            sem_val;
  logic [7:0]    q_tid[Depth];
  logic [15:0]   q_left[Depth];
  logic          q_timed[Depth];
  int            q_cnt;

  csem_pkg::res_t pending_results[$];
  csem_pkg::req_t request_q[$];
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_off = 0;
  int     errors = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void bump_value(input int amt);
    sem_val = sem_val + amt;
    if (sem_val > ValCap) sem_val = ValCap;
    if (sem_val < ValFloor) sem_val = ValFloor;
  endfunction

  function automatic void push_result(input csem_pkg::kind_e k, input logic [7:0] tid,
                                      input logic sig, input int ret,
                                      input logic lst);
    csem_pkg::res_t r;
    r.kind = k;
    r.thread_id_res = tid;
    r.by_signal = sig;
    r.return_value = ret[15:0];
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void restart_semaphore(input logic [15:0] init);
    sem_val = init;
    q_cnt = 0;
  endfunction

  // Work out the results of one accepted request and update the shadow state.
  function automatic void predict_semaphore(input csem_pkg::req_t rq);
    int n, amt, d, kept, rel;
    logic expire;
    n = rq.signal_count;
    case (csem_pkg::mode_e'(rq.mode))
      csem_pkg::MODE_WAIT: begin
        if (sem_val - 1 >= 0) begin
          bump_value(-1);
          push_result(csem_pkg::KIND_GRANTED, rq.thread_id, 1'b1, 1, 1'b1);
        end else if (q_cnt >= Depth) begin
          push_result(csem_pkg::KIND_FULL, rq.thread_id, 1'b0, 0, 1'b1);
        end else begin
          bump_value(-1);
          q_tid[q_cnt] = rq.thread_id;
          q_left[q_cnt] = rq.max_wait;
          q_timed[q_cnt] = (rq.max_wait != 0);
          q_cnt++;
          push_result(csem_pkg::KIND_BLOCKED, rq.thread_id, 1'b0, 0, 1'b1);
        end
      end
      csem_pkg::MODE_SIGNAL: begin
        if (n < 0) begin
          push_result(csem_pkg::KIND_DONE, 8'd0, 1'b0, n, 1'b1);
        end else begin
          amt = (n == 0) ? 1 : n;
          bump_value(amt);
          d = (q_cnt < amt) ? q_cnt : amt;
          for (int i = 0; i < d; i++)
            push_result(csem_pkg::KIND_RELEASED, q_tid[i], 1'b1, 1, 1'b0);
          for (int j = 0; j + d < q_cnt; j++) begin
            q_tid[j] = q_tid[j + d];
            q_left[j] = q_left[j + d];
            q_timed[j] = q_timed[j + d];
          end
          q_cnt -= d;
          push_result(csem_pkg::KIND_DONE, 8'd0, 1'b0, (n == 0) ? 0 : d, 1'b1);
        end
      end
      csem_pkg::MODE_TICK: begin
        kept = 0;
        rel = 0;
        for (int i = 0; i < q_cnt; i++) begin
          expire = 1'b0;
          if (q_timed[i]) begin
            if (q_left[i] <= 1) begin
              q_left[i] = 0;
              expire = 1'b1;
            end else begin
              q_left[i] = q_left[i] - 16'd1;
            end
          end
          if (expire) begin
            bump_value(1);
            push_result(csem_pkg::KIND_RELEASED, q_tid[i], 1'b0, 0, 1'b0);
            rel++;
          end else begin
            q_tid[kept] = q_tid[i];
            q_left[kept] = q_left[i];
            q_timed[kept] = q_timed[i];
            kept++;
          end
        end
        q_cnt = kept;
        push_result(csem_pkg::KIND_DONE, 8'd0, 1'b0, rel, 1'b1);
      end
      default: push_result(csem_pkg::KIND_DONE, 8'd0, 1'b0, 0, 1'b1);
    endcase
  endfunction

  // Driver: offer the next request; hold it while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_semaphore(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with an occasional long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    csem_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data_o));
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.kind !== want.kind)
          report_mismatch($sformatf("kind %0d want %0d", out_data_o.kind, want.kind));
        if (out_data_o.thread_id_res !== want.thread_id_res)
          report_mismatch($sformatf("thread %0d want %0d",
                                    out_data_o.thread_id_res, want.thread_id_res));
        if (out_data_o.by_signal !== want.by_signal)
          report_mismatch($sformatf("by_signal %0b want %0b",
                                    out_data_o.by_signal, want.by_signal));
        if (out_data_o.return_value !== want.return_value)
          report_mismatch($sformatf("return %0d want %0d",
                                    out_data_o.return_value, want.return_value));
        if (out_data_o.last !== want.last)
          report_mismatch($sformatf("last %0b want %0b", out_data_o.last, want.last));
      end
    end
  end

  function automatic csem_pkg::req_t make_req(input csem_pkg::mode_e m, input int tid,
                                              input int mw, input int n);
    csem_pkg::req_t r;
    r.mode = m;
    r.thread_id = tid[7:0];
    r.max_wait = mw[15:0];
    r.signal_count = n[15:0];
    return r;
  endfunction

  // Mostly waits with short timeouts, ticks and small signals; some extremes.
  function automatic csem_pkg::req_t random_req();
    int p;
    p = $urandom_range(99);
    if (p < 45)
      return make_req(csem_pkg::MODE_WAIT, $urandom_range(255),
                      ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(4),
                      $urandom_range(65535));
    if (p < 70)
      return make_req(csem_pkg::MODE_TICK, $urandom_range(255), $urandom_range(65535),
                      $urandom_range(65535));
    if (p < 95)
      return make_req(csem_pkg::MODE_SIGNAL, $urandom_range(255), $urandom_range(65535),
                      ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(3));
    return make_req(csem_pkg::MODE_NONE, $urandom_range(255), $urandom_range(65535),
                    $urandom_range(65535));
  endfunction

  task automatic write_initial(input logic [15:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    restart_semaphore(v);
  endtask

  // Let the queued requests drain, then the results, then the tail latency.
  task automatic drain();
    while (request_q.size() > 0 || in_valid_i || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
  endtask

  initial begin
    restart_semaphore(16'd0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty semaphore, blocking until full, then the special cases.
    for (int i = 0; i < Depth; i++)
      request_q.push_back(make_req(csem_pkg::MODE_WAIT, (i == 0) ? 255 : i,
                                   (i % 3 == 0) ? 0 : ((i == 1) ? 65535 : i % 3), 0));
    request_q.push_back(make_req(csem_pkg::MODE_WAIT, 8'hAA, 5, 0));
    request_q.push_back(make_req(csem_pkg::MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(csem_pkg::MODE_TICK, 0, 0, 0));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, -32768));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, 0));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, 2));
    request_q.push_back(make_req(csem_pkg::MODE_NONE, 255, 65535, -1));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, 32767));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, 32767));
    request_q.push_back(make_req(csem_pkg::MODE_SIGNAL, 0, 0, 32767));
    drain();

    // Random phases under different idle and stall mixes and settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_initial(16'd0);
        1: write_initial(16'd65535);
        2: write_initial(16'd3);
        default: write_initial(16'($urandom_range(8)));
      endcase
      idle_pct = (ph == 1 || ph == 3) ? 51 : 0;
      stall_pct = (ph == 2 || ph == 3) ? 51 : 0;
      if (ph == 3) begin
        idle_pct = 26;
        stall_pct = 26;
      end
      for (int i = 0; i < 65; i++) request_q.push_back(random_req());
      if (ph == 2) hold_off = 300;
      drain();
    end

    if (errors == 0)
      $display("counting_semaphore_timed_wait test passed");
    else
      $display("counting_semaphore_timed_wait test failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("counting_semaphore_timed_wait test failed");
    $finish;
  end

endmodule
